// ===== hw/rtl/odmd_pkg.sv =====
// ---------------------------------------------------------------------------
// odmd_pkg
// shared widths, register indexes and structs of the oversampled
// differential manchester decoder
// ---------------------------------------------------------------------------
package odmd_pkg;

   localparam int CNT_W     = 8;   // run length counter and symbol period
   localparam int BITS_W    = 8;   // decoded bit counter and frame length
   localparam int SYM_IDX_W = 9;   // symbol index within a frame
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BITS    = 1'b1;

   localparam logic [CNT_W-1:0]  SYMBOL_PERIOD_RST = 8'd7;
   localparam logic [BITS_W-1:0] FRAME_BITS_RST    = 8'd255;

   typedef struct packed {
      logic [CNT_W-1:0]  symbol_period;
      logic [BITS_W-1:0] frame_bits;
   } odmd_cfg_type;

   typedef struct packed {
      logic valid;
      logic data_bit;
      logic error;
      logic last;
   } odmd_result_type;

endpackage

// ===== hw/rtl/odmd_csr.sv =====
// ---------------------------------------------------------------------------
// odmd_csr
// configuration registers: symbol period and frame length
// ---------------------------------------------------------------------------
module odmd_csr
   import odmd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output odmd_cfg_type          cfg
);

   logic [CNT_W-1:0]  period_ff;
   logic [CNT_W-1:0]  period_in;
   logic [BITS_W-1:0] frame_bits_ff;
   logic [BITS_W-1:0] frame_bits_in;

   always_comb begin
      period_in     = period_ff;
      frame_bits_in = frame_bits_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SYMBOL_PERIOD: period_in     = csr_wdata[CNT_W-1:0];
            CSR_FRAME_BITS:    frame_bits_in = csr_wdata[BITS_W-1:0];
            default:           period_in     = period_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= SYMBOL_PERIOD_RST;
         frame_bits_ff <= FRAME_BITS_RST;
      end else begin
         period_ff     <= period_in;
         frame_bits_ff <= frame_bits_in;
      end
   end

   assign cfg.symbol_period = period_ff;
   assign cfg.frame_bits    = frame_bits_ff;

endmodule

// ===== hw/rtl/odmd_core.sv =====
// ---------------------------------------------------------------------------
// odmd_core
// run length measurement, symbol extraction and bit decode for one sample
// ---------------------------------------------------------------------------
module odmd_core
   import odmd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic            sample_bit,
   input  logic            frame_start,
   input  odmd_cfg_type    cfg,
   output odmd_result_type result
);

   logic                 level_ff,  level_in;
   logic [CNT_W-1:0]     count_ff,  count_in;
   logic [SYM_IDX_W-1:0] sym_idx_ff, sym_idx_in;
   logic                 prev_ff,   prev_in;
   logic [BITS_W-1:0]    done_ff,   done_in;
   logic                 active_ff, active_in;

   logic                 take;
   logic                 sym;
   logic [CNT_W:0]       count_inc;
   logic [CNT_W:0]       count_dbl;
   logic [BITS_W-1:0]    done_inc;
   odmd_result_type      res;

   assign count_inc = {1'b0, count_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign count_dbl = {count_ff, 1'b0};
   assign done_inc  = done_ff + {{(BITS_W-1){1'b0}}, 1'b1};

   always_comb begin
      level_in   = level_ff;
      count_in   = count_ff;
      sym_idx_in = sym_idx_ff;
      prev_in    = prev_ff;
      done_in    = done_ff;
      active_in  = active_ff;
      take       = 1'b0;
      sym        = level_ff;
      res        = '0;

      priority if (frame_start) begin
         level_in   = sample_bit;
         count_in   = '0;
         sym_idx_in = '0;
         prev_in    = 1'b0;
         done_in    = '0;
         active_in  = 1'b1;
      end else if (active_ff) begin
         if (sample_bit != level_ff) begin
            // level change closes the run; more than half a period counts
            level_in = sample_bit;
            count_in = {{(CNT_W-1){1'b0}}, 1'b1};
            take     = count_dbl > {1'b0, cfg.symbol_period};
         end else if (count_inc >= {1'b0, cfg.symbol_period}) begin
            count_in = '0;
            take     = 1'b1;
         end else begin
            count_in = count_inc[CNT_W-1:0];
         end
      end else begin
         // outside a frame the sample is dropped
         take = 1'b0;
      end

      if (take) begin
         prev_in    = sym;
         sym_idx_in = sym_idx_ff + {{(SYM_IDX_W-1){1'b0}}, 1'b1};
         priority if (sym_idx_ff == '0) begin
            done_in      = {{(BITS_W-1){1'b0}}, 1'b1};
            res.valid    = 1'b1;
            res.data_bit = sym;
            res.last     = done_in >= cfg.frame_bits;
         end else if (sym_idx_ff[0]) begin
            // mid-bit transition missing
            if (sym == prev_ff) begin
               res.valid = 1'b1;
               res.error = 1'b1;
               res.last  = 1'b1;
            end
         end else begin
            done_in      = done_inc;
            res.valid    = 1'b1;
            res.data_bit = (sym == prev_ff);
            res.last     = done_inc >= cfg.frame_bits;
         end
         if (res.valid && res.last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= 1'b0;
         count_ff   <= '0;
         sym_idx_ff <= '0;
         prev_ff    <= 1'b0;
         done_ff    <= '0;
         active_ff  <= 1'b0;
      end else if (step) begin
         level_ff   <= level_in;
         count_ff   <= count_in;
         sym_idx_ff <= sym_idx_in;
         prev_ff    <= prev_in;
         done_ff    <= done_in;
         active_ff  <= active_in;
      end
   end

   assign result = res;

`ifndef SYNTH
   a_result_needs_frame: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> active_ff && !frame_start)
      else $error("result produced outside an active frame");

   a_error_ends_frame: assert property (@(posedge clock) disable iff (reset)
      step && res.valid && res.error |=> !active_ff)
      else $error("frame still active after an error");

   a_start_clears_index: assert property (@(posedge clock) disable iff (reset)
      step && frame_start |=> sym_idx_ff == '0 && done_ff == '0 && active_ff)
      else $error("frame start did not restart the decoder");
`endif

endmodule

// ===== hw/rtl/oversampled_diff_manchester_decoder.sv =====
// ---------------------------------------------------------------------------
// oversampled_diff_manchester_decoder
// differential manchester decoder for an oversampled line, one sample per
// transaction, zero or one decoded bit per sample
// ---------------------------------------------------------------------------
// the block takes one line sample per cycle and sustains that rate with no
// gaps unless the result port stalls: a sample is registered at the input,
// decoded by a single pass of compare and counter logic, and a decoded bit
// is registered in the result register. half-bit symbols are recovered by
// run length against symbol_period; a sample with frame_start set restarts
// the decoder and yields nothing, and samples outside a frame are dropped.
// each result carries data_bit, error (missing mid-bit transition, data_bit
// then 0) and last (final bit of the frame or error); after last the block
// waits for the next frame_start. the input side only stalls while a result
// is held by a stalled result port. write configuration only while idle.
// ---------------------------------------------------------------------------
module oversampled_diff_manchester_decoder
   import odmd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input samples
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_sample_bit,
   input  logic                  req_frame_start,
   // decoded bits
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_data_bit,
   output logic                  rsp_error,
   output logic                  rsp_last,
   // configuration
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   odmd_cfg_type    cfg;
   odmd_result_type result;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_sample_ff;
   logic in_start_ff;

   // result register
   logic out_valid_ff, out_valid_in;
   logic out_data_ff;
   logic out_error_ff;
   logic out_last_ff;

   logic req_take;
   logic advance;

   // the held sample moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   odmd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   odmd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .sample_bit  (in_sample_ff),
      .frame_start (in_start_ff),
      .cfg         (cfg),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && result.valid) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_sample_bit;
         in_start_ff  <= req_frame_start;
      end
      if (advance && result.valid) begin
         out_data_ff  <= result.data_bit;
         out_error_ff <= result.error;
         out_last_ff  <= result.last;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_data_bit = out_data_ff;
   assign rsp_error    = out_error_ff;
   assign rsp_last     = out_last_ff;

`ifndef SYNTH
   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance && result.valid |=> rsp_valid)
      else $error("decoded bit not loaded into result register");

   a_error_bit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && !rsp_data_bit)
      else $error("error result without last or with data bit set");
`endif

endmodule
